FILE: sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear-probe hash table: status codes,
// operation codes, sequencer states and configuration defaults.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // Default geometry
    localparam int TABLE_SLOTS_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;

    // Fixed field widths
    localparam int HASH_BITS  = 32;
    localparam int VALUE_BITS = 32;
    localparam int STATUS_W   = 3;
    localparam int MAX_W      = 6;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register map: word index taken from paddr[2]
    localparam logic REG_MAX_ENTRIES = 1'b0;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 6'd48;

    typedef enum logic [STATUS_W-1:0] {
        STAT_UPDATED   = 3'd0,
        STAT_INSERTED  = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    typedef enum logic {
        FUNC_SET = 1'b0,
        FUNC_GET = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_PROBE
    } t_state;

endpackage

FILE: sv/linear_probe_hash_table.sv
// Timing: with a power-of-two slot count the home slot is read at the accept
//   edge and each further slot is read in turn; the result is registered once
//   the probe ends and the output register is free. Other slot counts first
//   form the hash remainder in ST_HASH (reciprocal multiply) and ST_MOD
//   (multiply and subtract). Throughput: one item at a time; no new request
//   is taken until the result is registered. Reset: clear TABLE_SLOTS slots.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing. A small sequencer walks the
// slot memory one slot per cycle from the home slot until it meets the key,
// an empty slot, or has visited every slot, then sets, updates or reads.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = lpht_pkg::KEY_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [KEY_BITS-1:0]               i_key_id,
    input  logic [lpht_pkg::HASH_BITS-1:0]    i_key_hash,
    input  logic [lpht_pkg::VALUE_BITS-1:0]   i_value_in,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lpht_pkg::STATUS_W-1:0]     o_status,
    output logic [lpht_pkg::VALUE_BITS-1:0]   o_value_out,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpht_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lpht_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lpht_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int WORD_W  = 1 + KEY_BITS + lpht_pkg::VALUE_BITS;
    localparam int HB      = lpht_pkg::HASH_BITS;
    localparam int REM_SH  = HB + SLOT_W;
    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [HB-1:0]     SLOTS_H   = HB'(TABLE_SLOTS);
    localparam logic [HB:0]       RECIP     =
        (HB + 1)'(((64'd1 << REM_SH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

    // Sequencer and request registers
    lpht_pkg::t_state                 r_state, n_state;
    logic [SLOT_W-1:0]                r_idx, n_idx;
    logic [SLOT_W-1:0]                r_cnt, n_cnt;
    logic [HB-1:0]                    r_quot, n_quot;
    logic [lpht_pkg::HASH_BITS-1:0]   r_hash, n_hash;
    lpht_pkg::t_func                  r_func, n_func;
    logic [KEY_BITS-1:0]              r_key, n_key;
    logic [lpht_pkg::VALUE_BITS-1:0]  r_val, n_val;
    logic [lpht_pkg::MAX_W-1:0]       r_live, n_live;
    logic [lpht_pkg::MAX_W-1:0]       r_max;
    // Output register
    logic                             r_out_valid, n_out_valid;
    lpht_pkg::t_status                r_status, n_status;
    logic [lpht_pkg::VALUE_BITS-1:0]  r_vout, n_vout;

    // Memory interface
    logic                             ram_we, ram_re;
    logic [SLOT_W-1:0]                ram_waddr, ram_raddr;
    logic [WORD_W-1:0]                ram_wdata, ram_rdata;

    // Slot decode and probe helpers
    logic                             slot_valid, slot_hit, slot_empty, probe_last;
    logic [KEY_BITS-1:0]              slot_key;
    logic [lpht_pkg::VALUE_BITS-1:0]  slot_value;
    logic [SLOT_W-1:0]                idx_next;
    logic [2*HB:0]                    quot_prod;
    logic [HB-1:0]                    quot_next, quot_mul, rem_full;
    logic [SLOT_W-1:0]                home_slot;
    logic                             out_free, accept, cfg_wr;

    lpht_slot_ram #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (WORD_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Decode the slot word of the last read
    assign slot_valid = ram_rdata[WORD_W-1];
    assign slot_key   = ram_rdata[lpht_pkg::VALUE_BITS +: KEY_BITS];
    assign slot_value = ram_rdata[lpht_pkg::VALUE_BITS-1:0];
    assign slot_hit   = slot_valid && (slot_key == r_key);
    assign slot_empty = !slot_valid;
    assign probe_last = (r_cnt == LAST_SLOT);
    assign idx_next   = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;

    // Hash remainder: quotient by reciprocal multiply, then multiply and subtract
    assign quot_prod = {{(HB + 1){1'b0}}, r_hash} * {{HB{1'b0}}, RECIP};
    assign quot_next = HB'(quot_prod >> REM_SH);
    assign quot_mul  = r_quot * SLOTS_H;
    assign rem_full  = r_hash - quot_mul;
    assign home_slot = rem_full[SLOT_W-1:0];

    assign o_in_ready = (r_state == lpht_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Next state, memory control and result
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_quot      = r_quot;
        n_hash      = r_hash;
        n_func      = r_func;
        n_key       = r_key;
        n_val       = r_val;
        n_live      = r_live;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_vout      = r_vout;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = {1'b1, r_key, r_val};
        ram_re      = 1'b0;
        ram_raddr   = r_idx;

        unique case (r_state)
            lpht_pkg::ST_CLEAR: begin
                // Sweep every slot and drop its valid mark
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_idx == LAST_SLOT) begin
                    n_idx   = '0;
                    n_state = lpht_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            lpht_pkg::ST_IDLE: begin
                if (accept) begin
                    n_func   = lpht_pkg::t_func'(i_func);
                    n_key    = i_key_id;
                    n_val    = i_value_in;
                    n_hash   = i_key_hash;
                    n_cnt    = '0;
                    if (IS_POW2) begin
                        // Home slot is the low hash bits: read it right away
                        n_idx     = i_key_hash[SLOT_W-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = i_key_hash[SLOT_W-1:0];
                        n_state   = lpht_pkg::ST_PROBE;
                    end else begin
                        n_idx   = '0;
                        n_state = lpht_pkg::ST_HASH;
                    end
                end
            end

            lpht_pkg::ST_HASH: begin
                // Form the quotient of the hash by the slot count
                n_quot  = quot_next;
                n_state = lpht_pkg::ST_MOD;
            end

            lpht_pkg::ST_MOD: begin
                // Take the remainder as the home slot and read it
                n_idx     = home_slot;
                ram_re    = 1'b1;
                ram_raddr = home_slot;
                n_state   = lpht_pkg::ST_PROBE;
            end

            lpht_pkg::ST_PROBE: begin
                if (!(slot_hit || slot_empty || probe_last)) begin
                    // Advance to the next slot with wrap-around
                    ram_re    = 1'b1;
                    ram_raddr = idx_next;
                    n_idx     = idx_next;
                    n_cnt     = r_cnt + 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_vout      = '0;
                    n_state     = lpht_pkg::ST_IDLE;
                    if (r_func == lpht_pkg::FUNC_SET) begin
                        priority if (slot_hit) begin
                            ram_we   = 1'b1;
                            n_status = lpht_pkg::STAT_UPDATED;
                        end else if (slot_empty && (r_live < r_max)) begin
                            ram_we   = 1'b1;
                            n_live   = r_live + 1'b1;
                            n_status = lpht_pkg::STAT_INSERTED;
                        end else begin
                            n_status = lpht_pkg::STAT_FULL;
                        end
                    end else begin
                        if (slot_hit) begin
                            n_vout   = slot_value;
                            n_status = lpht_pkg::STAT_FOUND;
                        end else begin
                            n_status = lpht_pkg::STAT_NOT_FOUND;
                        end
                    end
                end
            end

            default: begin
                n_state = lpht_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpht_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_quot   <= n_quot;
        r_hash   <= n_hash;
        r_func   <= n_func;
        r_key    <= n_key;
        r_val    <= n_val;
        r_status <= n_status;
        r_vout   <= n_vout;
    end

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == lpht_pkg::REG_MAX_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= lpht_pkg::MAX_ENTRIES_RST;
        end else if (cfg_wr) begin
            r_max <= pwdata[lpht_pkg::MAX_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lpht_pkg::REG_MAX_ENTRIES)
                  ? {{(lpht_pkg::APB_DATA_W - lpht_pkg::MAX_W){1'b0}}, r_max}
                  : '0;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_vout;

endmodule

FILE: sv/lpht_slot_ram.sv
// ----------------------------------------------------------------------------
// lpht_slot_ram
// Slot storage: one write port and one read port, read data registered.
// Each word holds the valid mark, the key and the value of one slot.
// ----------------------------------------------------------------------------
module lpht_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 49
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: hold the last word while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
